// ----- hw/rtl/mtde_pkg.sv -----
// Shared types, constants and word functions of the MT19937 draw engine.
// Used by mtde_words, mtde_ctrl and mt19937_draw_engine_top; no dependencies.
`default_nettype none

package mtde_pkg;

   localparam int ADDR_W = 10;

   localparam logic [ADDR_W-1:0] N_WORDS   = 10'd624;
   localparam logic [ADDR_W-1:0] LAST_WORD = 10'd623;
   localparam logic [ADDR_W-1:0] TAP_OFS   = 10'd397;

   localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
   localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
   localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
   localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

   localparam logic [6:0] MAX_BITS  = 7'd64;
   localparam logic [6:0] WORD_BITS = 7'd32;

   typedef enum logic [2:0] {
      CMD_LOAD   = 3'd0,
      CMD_SETPOS = 3'd1,
      CMD_BITS   = 3'd2,
      CMD_FRAC   = 3'd3,
      CMD_BELOW  = 3'd4
   } mtde_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEN_A,
      ST_LEN_B,
      ST_FETCH,
      ST_WAIT,
      ST_CHECK,
      ST_TW_PRIME,
      ST_TW_SEED,
      ST_TW_RD,
      ST_TW_WR,
      ST_DONE
   } mtde_state_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [ADDR_W-1:0] word_index;
      logic [31:0]       word_value;
      logic [6:0]        bit_count;
      logic [63:0]       limit;
   } mtde_req_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [31:0]       wr_data;
   } mtde_mem_req_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] value;
      logic        error;
   } mtde_result_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] v;
      v = w;
      v = v ^ (v >> 11);
      v = v ^ ((v << 7) & TEMPER_B);
      v = v ^ ((v << 15) & TEMPER_C);
      v = v ^ (v >> 18);
      return v;
   endfunction

   // One word of the twist: cur is word i, nxt word i+1, far word i+397.
   function automatic logic [31:0] twist(input logic [31:0] cur,
                                         input logic [31:0] nxt,
                                         input logic [31:0] far);
      logic [31:0] y;
      y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
      return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'h0);
   endfunction

   // Position of the top set bit plus one, zero for an all-zero byte.
   function automatic logic [3:0] byte_len(input logic [7:0] b);
      logic [3:0] len;
      len = 4'd0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            len = 4'(k + 1);
         end
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mt19937_draw_engine_top.sv -----
// MT19937 draw engine top level: stream ports, result register, sequencer and state store.
// Depends on mtde_pkg, mtde_words and mtde_ctrl.
//
// Usage: one command beat enters on req_; draws return one beat on rsp_.
//   req_tuser holds the command: load word, set position, draw bits,
//   draw unit fraction, draw below. Load and a valid set position give no
//   beat; unknown commands are dropped. Invalid bit count, zero limit or a
//   position above 624 return a beat with rsp_tuser (error) set and data 0.
// Throughput: one command at a time. Load and a valid set position finish on
//   accept. A draw fetches each word it needs, one or two, and waits for its
//   read before the result; draw below first runs the bit-length search, then
//   compares each candidate, and repeats the word draws for each rejected one.
//   Each word read is one access to the state memory, a registered read.
// Twist: when the read position reaches 624, the next draw first runs the
//   twist pass over the memory: prime and seed states, then read and write
//   states for each word, once every 624 words drawn.
// Reset: read position goes to 624 (twist on first draw). The state words
//   are not cleared; load all 624 before drawing.
// Stall: the result register holds a beat while rsp_tready is low; the next
//   command is still taken, and its result waits until the register frees.
`default_nettype none

module mt19937_draw_engine_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [9:0] word_index, [41:10] word_value, [48:42] bit_count, [112:49] limit, rest zero
   input  wire logic [119:0]  req_tdata,
   // [2:0] command
   input  wire logic [2:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [63:0] random_value
   output logic [63:0]        rsp_tdata,
   // [0] error
   output logic               rsp_tuser
);

   mtde_pkg::mtde_req_type     req;
   mtde_pkg::mtde_result_type  result;
   mtde_pkg::mtde_mem_req_type mem;
   logic [31:0]                rd_data_a;
   logic [31:0]                rd_data_b;
   logic                       slot_free;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_error_ff, rsp_error_in;

   // Unpack the command beat.
   assign req.cmd        = req_tuser;
   assign req.word_index = req_tdata[9:0];
   assign req.word_value = req_tdata[41:10];
   assign req.bit_count  = req_tdata[48:42];
   assign req.limit      = req_tdata[112:49];

   // The register may load when empty or when its beat leaves this cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   mtde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .slot_free (slot_free),
      .result    (result),
      .mem       (mem),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mtde_words u_words (
      .clock     (clock),
      .mem       (mem),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result.value;
         rsp_error_in = result.error;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_error_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mtde_words.sv -----
// Generator state store: 624 x 32 words, one write and two registered reads.
// Depends on mtde_pkg for the address width, the depth and the access struct.
`default_nettype none

module mtde_words (
   input  wire logic                       clock,
   input  wire mtde_pkg::mtde_mem_req_type mem,
   output logic [31:0]                     rd_data_a,
   output logic [31:0]                     rd_data_b
);

   logic [31:0] words_ff [0:mtde_pkg::LAST_WORD];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem.wr_en) begin
         words_ff[mem.wr_addr] <= mem.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem.rd_en) begin
         rd_a_ff <= words_ff[mem.rd_addr_a];
         rd_b_ff <= words_ff[mem.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mtde_ctrl.sv -----
// Command sequencer: loads, position updates, word draws, the twist pass,
// bit-length search and rejection loop. Depends on mtde_pkg; drives mtde_words.
`default_nettype none

module mtde_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire mtde_pkg::mtde_req_type req,
   input  wire logic                   slot_free,
   output mtde_pkg::mtde_result_type   result,
   output mtde_pkg::mtde_mem_req_type  mem,
   input  wire logic [31:0]            rd_data_a,
   input  wire logic [31:0]            rd_data_b
);

   mtde_pkg::mtde_state_type state_ff, state_in;

   logic [mtde_pkg::ADDR_W-1:0] pos_ff, pos_in;
   logic [mtde_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [2:0]                  cmd_ff, cmd_in;
   logic [6:0]                  nbits_ff, nbits_in;
   logic [63:0]                 limit_ff, limit_in;
   logic [3:0]                  bytelen_ff [8];
   logic [3:0]                  bytelen_in [8];
   logic                        second_ff, second_in;
   logic [31:0]                 lo_ff, lo_in;
   logic [31:0]                 cur_ff, cur_in;
   logic [63:0]                 val_ff, val_in;
   logic                        err_ff, err_in;

   logic [mtde_pkg::ADDR_W-1:0] next_addr;
   logic [mtde_pkg::ADDR_W-1:0] tap_sum;
   logic [mtde_pkg::ADDR_W-1:0] tap_addr;
   logic [31:0]                 tempered;
   logic [31:0]                 shifted;
   logic [4:0]                  shamt;
   logic                        need_two;
   logic [6:0]                  len_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtde_pkg::ST_IDLE;
         pos_ff   <= mtde_pkg::N_WORDS;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmd_ff     <= cmd_in;
      nbits_ff   <= nbits_in;
      limit_ff   <= limit_in;
      bytelen_ff <= bytelen_in;
      second_ff  <= second_in;
      lo_ff      <= lo_in;
      cur_ff     <= cur_in;
      val_ff     <= val_in;
      err_ff     <= err_in;
   end

   // Twist neighbors of word idx, wrapping around the ring.
   assign next_addr = (idx_ff == mtde_pkg::LAST_WORD) ? '0 : idx_ff + 10'd1;
   assign tap_sum   = idx_ff + mtde_pkg::TAP_OFS;
   assign tap_addr  = (tap_sum >= mtde_pkg::N_WORDS) ? tap_sum - mtde_pkg::N_WORDS : tap_sum;

   assign tempered = mtde_pkg::temper(rd_data_a);
   // Keep the top n bits of a word: the shift is (32 - n) or (64 - n), both -n mod 32.
   assign shamt    = 5'(7'd0 - nbits_ff);
   assign shifted  = tempered >> shamt;
   assign need_two = (cmd_ff == mtde_pkg::CMD_FRAC) || (nbits_ff > mtde_pkg::WORD_BITS);

   always_comb begin
      len_sum = 7'd0;
      for (int k = 0; k < 8; k++) begin
         if (bytelen_ff[k] != 4'd0) begin
            len_sum = 7'(8 * k) + 7'(bytelen_ff[k]);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      cmd_in     = cmd_ff;
      nbits_in   = nbits_ff;
      limit_in   = limit_ff;
      bytelen_in = bytelen_ff;
      second_in  = second_ff;
      lo_in      = lo_ff;
      cur_in     = cur_ff;
      val_in     = val_ff;
      err_in     = err_ff;

      req_ready    = 1'b0;
      result.valid = 1'b0;
      result.value = val_ff;
      result.error = err_ff;
      mem          = '0;

      case (state_ff)
         mtde_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = req.cmd;
               nbits_in  = req.bit_count;
               limit_in  = req.limit;
               second_in = 1'b0;
               val_in    = '0;
               err_in    = 1'b0;
               case (req.cmd)
                  mtde_pkg::CMD_LOAD: begin
                     if (req.word_index < mtde_pkg::N_WORDS) begin
                        mem.wr_en   = 1'b1;
                        mem.wr_addr = req.word_index;
                        mem.wr_data = req.word_value;
                     end
                  end
                  mtde_pkg::CMD_SETPOS: begin
                     if (req.word_index > mtde_pkg::N_WORDS) begin
                        err_in   = 1'b1;
                        state_in = mtde_pkg::ST_DONE;
                     end else begin
                        pos_in = req.word_index;
                     end
                  end
                  mtde_pkg::CMD_BITS: begin
                     if (req.bit_count == 7'd0 || req.bit_count > mtde_pkg::MAX_BITS) begin
                        err_in   = 1'b1;
                        state_in = mtde_pkg::ST_DONE;
                     end else begin
                        state_in = mtde_pkg::ST_FETCH;
                     end
                  end
                  mtde_pkg::CMD_FRAC: begin
                     state_in = mtde_pkg::ST_FETCH;
                  end
                  mtde_pkg::CMD_BELOW: begin
                     if (req.limit == 64'd0) begin
                        err_in   = 1'b1;
                        state_in = mtde_pkg::ST_DONE;
                     end else begin
                        state_in = mtde_pkg::ST_LEN_A;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         mtde_pkg::ST_LEN_A: begin
            for (int k = 0; k < 8; k++) begin
               bytelen_in[k] = mtde_pkg::byte_len(limit_ff[8*k +: 8]);
            end
            state_in = mtde_pkg::ST_LEN_B;
         end

         mtde_pkg::ST_LEN_B: begin
            nbits_in = len_sum;
            state_in = mtde_pkg::ST_FETCH;
         end

         mtde_pkg::ST_FETCH: begin
            if (pos_ff == mtde_pkg::N_WORDS) begin
               idx_in   = '0;
               state_in = mtde_pkg::ST_TW_PRIME;
            end else begin
               mem.rd_en     = 1'b1;
               mem.rd_addr_a = pos_ff;
               pos_in        = pos_ff + 10'd1;
               state_in      = mtde_pkg::ST_WAIT;
            end
         end

         mtde_pkg::ST_TW_PRIME: begin
            mem.rd_en     = 1'b1;
            mem.rd_addr_a = '0;
            state_in      = mtde_pkg::ST_TW_SEED;
         end

         mtde_pkg::ST_TW_SEED: begin
            cur_in        = rd_data_a;
            mem.rd_en     = 1'b1;
            mem.rd_addr_a = next_addr;
            mem.rd_addr_b = tap_addr;
            state_in      = mtde_pkg::ST_TW_WR;
         end

         mtde_pkg::ST_TW_RD: begin
            mem.rd_en     = 1'b1;
            mem.rd_addr_a = next_addr;
            mem.rd_addr_b = tap_addr;
            state_in      = mtde_pkg::ST_TW_WR;
         end

         mtde_pkg::ST_TW_WR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = idx_ff;
            mem.wr_data = mtde_pkg::twist(cur_ff, rd_data_a, rd_data_b);
            // word i+1 is still untouched: carry it as the next current word
            cur_in      = rd_data_a;
            if (idx_ff == mtde_pkg::LAST_WORD) begin
               pos_in   = '0;
               state_in = mtde_pkg::ST_FETCH;
            end else begin
               idx_in   = idx_ff + 10'd1;
               state_in = mtde_pkg::ST_TW_RD;
            end
         end

         mtde_pkg::ST_WAIT: begin
            if (need_two && !second_ff) begin
               lo_in     = tempered;
               second_in = 1'b1;
               state_in  = mtde_pkg::ST_FETCH;
            end else begin
               if (cmd_ff == mtde_pkg::CMD_FRAC) begin
                  val_in = {11'd0, lo_ff[31:5], tempered[31:6]};
               end else if (need_two) begin
                  val_in = {shifted, lo_ff};
               end else begin
                  val_in = {32'd0, shifted};
               end
               if (cmd_ff == mtde_pkg::CMD_BELOW) begin
                  state_in = mtde_pkg::ST_CHECK;
               end else begin
                  state_in = mtde_pkg::ST_DONE;
               end
            end
         end

         mtde_pkg::ST_CHECK: begin
            if (val_ff >= limit_ff) begin
               second_in = 1'b0;
               state_in  = mtde_pkg::ST_FETCH;
            end else begin
               state_in = mtde_pkg::ST_DONE;
            end
         end

         mtde_pkg::ST_DONE: begin
            if (slot_free) begin
               result.valid = 1'b1;
               state_in     = mtde_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mtde_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- test/mtde_draw_checker.sv -----
// Scoreboard for the MT19937 draw engine: watches both stream channels, predicts each result.
// Keeps its own copy of the 624-word generator state; uses only the command codes of mtde_pkg.
// Handed back to the testbench top: mismatch count, outstanding results and totals.
module mtde_draw_checker
   import mtde_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [119:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         end_check,
   output int           fail_count,
   output int           pending,
   output int           compared,
   output int           error_results
);

   localparam int          STATE_DEPTH = 624;
   localparam int          TAP_DIST    = 397;
   localparam logic [31:0] TWIST_XOR   = 32'h9908_b0df;
   localparam logic [31:0] HIGH_BIT    = 32'h8000_0000;
   localparam logic [31:0] LOW_BITS    = 32'h7fff_ffff;
   localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;

   typedef struct packed {
      logic [63:0] value;
      logic        error;
   } draw_outcome_t;

   logic [31:0]   gen_words [STATE_DEPTH];
   int unsigned   gen_pos;
   draw_outcome_t pending_draws [$];
   draw_outcome_t oldest;
   int            mismatches = 0;
   int            checked = 0;
   int            flagged = 0;
   bit            leftovers_done = 1'b0;

   logic [9:0]    beat_index;
   logic [31:0]   beat_word;
   logic [6:0]    beat_bits;
   logic [63:0]   beat_limit;
   logic [63:0]   high_part, low_part, candidate;
   int            limit_len;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("draw check: %s", what);
   endtask

   // Next tempered word; regenerate the whole state once the position runs off the end.
   function automatic logic [31:0] next_tempered();
      logic [31:0] y;
      logic [31:0] v;
      if (gen_pos >= STATE_DEPTH) begin
         for (int i = 0; i < STATE_DEPTH; i++) begin
            y = (gen_words[i] & HIGH_BIT) | (gen_words[(i + 1) % STATE_DEPTH] & LOW_BITS);
            gen_words[i] = gen_words[(i + TAP_DIST) % STATE_DEPTH] ^ (y >> 1) ^
                           (y[0] ? TWIST_XOR : 32'h0);
         end
         gen_pos = 0;
      end
      v = gen_words[gen_pos];
      gen_pos++;
      v = v ^ (v >> 11);
      v = v ^ ((v << 7) & TEMPER_MASK_B);
      v = v ^ ((v << 15) & TEMPER_MASK_C);
      v = v ^ (v >> 18);
      return v;
   endfunction

   // n random bits, 1..64: low word first, top bits of the second word above it.
   function automatic logic [63:0] take_bits(input int unsigned n);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = next_tempered();
      if (n <= 32) begin
         return {32'd0, lo >> (32 - n)};
      end
      hi = next_tempered();
      hi = hi >> (64 - n);
      return {hi, lo};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (gen_words[i]) begin
            gen_words[i] = '0;
         end
         gen_pos = STATE_DEPTH;
         pending_draws.delete();
      end else begin
         // results first: a beat leaving now belongs to an earlier command
         if (rsp_tvalid && rsp_tready) begin
            if (pending_draws.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat value %h error %b",
                                         rsp_tdata, rsp_tuser));
            end else begin
               oldest = pending_draws.pop_front();
               checked++;
               if (rsp_tuser) begin
                  flagged++;
               end
               if (rsp_tdata !== oldest.value) begin
                  report_mismatch($sformatf("value %h, predicted %h", rsp_tdata, oldest.value));
               end
               if (rsp_tuser !== oldest.error) begin
                  report_mismatch($sformatf("error flag %b, predicted %b",
                                            rsp_tuser, oldest.error));
               end
            end
         end

         if (req_tvalid && req_tready) begin
            beat_index = req_tdata[9:0];
            beat_word  = req_tdata[41:10];
            beat_bits  = req_tdata[48:42];
            beat_limit = req_tdata[112:49];
            case (req_tuser)
               CMD_LOAD: begin
                  if (beat_index < STATE_DEPTH) begin
                     gen_words[beat_index] = beat_word;
                  end
               end
               CMD_SETPOS: begin
                  if (beat_index > STATE_DEPTH) begin
                     pending_draws.push_back('{value: 64'd0, error: 1'b1});
                  end else begin
                     gen_pos = beat_index;
                  end
               end
               CMD_BITS: begin
                  if (beat_bits == 0 || beat_bits > 64) begin
                     pending_draws.push_back('{value: 64'd0, error: 1'b1});
                  end else begin
                     pending_draws.push_back('{value: take_bits(beat_bits), error: 1'b0});
                  end
               end
               CMD_FRAC: begin
                  high_part = {32'd0, next_tempered()} >> 5;
                  low_part  = {32'd0, next_tempered()} >> 6;
                  pending_draws.push_back('{value: (high_part << 26) + low_part, error: 1'b0});
               end
               CMD_BELOW: begin
                  if (beat_limit == 0) begin
                     pending_draws.push_back('{value: 64'd0, error: 1'b1});
                  end else begin
                     limit_len = 0;
                     for (int k = 0; k < 64; k++) begin
                        if (beat_limit[k]) begin
                           limit_len = k + 1;
                        end
                     end
                     // reject until the candidate falls below the limit
                     do begin
                        candidate = take_bits(limit_len);
                     end while (candidate >= beat_limit);
                     pending_draws.push_back('{value: candidate, error: 1'b0});
                  end
               end
               default: begin
               end
            endcase
         end

         if (end_check && !leftovers_done) begin
            leftovers_done = 1'b1;
            while (pending_draws.size() != 0) begin
               oldest = pending_draws.pop_front();
               report_mismatch($sformatf("missing result beat, predicted value %h error %b",
                                         oldest.value, oldest.error));
            end
         end
      end
      fail_count    <= mismatches;
      pending       <= pending_draws.size();
      compared      <= checked;
      error_results <= flagged;
   end

endmodule

// ----- test/testbench.sv -----
// Top of the MT19937 draw engine testbench: clock, reset, command stimulus and the verdict.
// Depends on mtde_pkg, mt19937_draw_engine_top and the mtde_draw_checker scoreboard.
module testbench;
   import mtde_pkg::*;

   // command codes the block drops without a result
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
   localparam int         RANDOM_BEATS  = 700;
   localparam int         DRAIN_LIMIT   = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         end_check = 1'b0;

   int fail_count, pending, compared, error_results;

   // idling switch: high means both sides run back to back
   bit calm = 1'b0;
   int stall_left = 0;

   int n_loads = 0;
   int n_setpos = 0;
   int n_draws = 0;
   int n_dropped = 0;

   mt19937_draw_engine_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mtde_draw_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .end_check     (end_check),
      .fail_count    (fail_count),
      .pending       (pending),
      .compared      (compared),
      .error_results (error_results)
   );

   always #5 clock = ~clock;

   // Result side back-pressure: drop tready for bursts of random length at random,
   // hold it high throughout reset and whenever the calm switch is on.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Send one command beat. Fields the command does not read get random bits so
   // that the block is seen to ignore them. Optionally idle first, then present
   // the beat at a falling edge and hold it until a rising edge with tready high.
   task automatic send_beat(input logic [2:0] cmd, input logic [9:0] idx,
                            input logic [31:0] val, input logic [6:0] nbits,
                            input logic [63:0] lim);
      int gap;
      if (cmd != CMD_LOAD && cmd != CMD_SETPOS) idx = 10'($urandom);
      if (cmd != CMD_LOAD) val = $urandom;
      if (cmd != CMD_BITS) nbits = 7'($urandom);
      if (cmd != CMD_BELOW) lim = rand64();
      case (cmd)
         CMD_LOAD:   n_loads++;
         CMD_SETPOS: n_setpos++;
         CMD_BITS, CMD_FRAC, CMD_BELOW: n_draws++;
         default:    n_dropped++;
      endcase
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      // [9:0] word_index, [41:10] word_value, [48:42] bit_count, [112:49] limit
      req_tdata  <= {7'd0, lim, nbits, val, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("timeout: draw engine stopped making progress");
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int          sent;
      int          sel;
      int          k;
      int          guard;
      logic [9:0]  idx;
      logic [6:0]  nbits;
      logic [63:0] lim;

      // Hold synchronous reset, then release it at a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // All-zero state: load every word with zero, then draw across a twist.
      // The state must stay zero and every draw must return zero.
      for (int i = 0; i < 624; i++) begin
         send_beat(CMD_LOAD, 10'(i), 32'd0, '0, '0);
      end
      send_beat(CMD_BITS, '0, '0, 7'd64, '0);
      send_beat(CMD_FRAC, '0, '0, '0, '0);
      send_beat(CMD_BELOW, '0, '0, '0, '1);

      // Load a full random state, with the all-ones and all-zero word at the start.
      for (int i = 0; i < 624; i++) begin
         send_beat(CMD_LOAD, 10'(i), (i == 0) ? 32'hffff_ffff : (i == 1) ? 32'd0 : $urandom,
                   '0, '0);
      end

      // Directed: out-of-range loads are dropped, positions above 624 flag an error.
      send_beat(CMD_LOAD, 10'd624, $urandom, '0, '0);
      send_beat(CMD_LOAD, 10'd1023, $urandom, '0, '0);
      send_beat(CMD_SETPOS, 10'd625, '0, '0, '0);
      send_beat(CMD_SETPOS, 10'd1023, '0, '0, '0);
      // position 624 forces a twist on the next draw
      send_beat(CMD_SETPOS, 10'd624, '0, '0, '0);
      send_beat(CMD_BITS, '0, '0, 7'd1, '0);
      send_beat(CMD_BITS, '0, '0, 7'd32, '0);
      send_beat(CMD_BITS, '0, '0, 7'd33, '0);
      send_beat(CMD_BITS, '0, '0, 7'd64, '0);
      send_beat(CMD_BITS, '0, '0, 7'd0, '0);
      send_beat(CMD_BITS, '0, '0, 7'd65, '0);
      send_beat(CMD_BITS, '0, '0, 7'd127, '0);
      // a two-word draw that straddles the twist
      send_beat(CMD_SETPOS, 10'd623, '0, '0, '0);
      send_beat(CMD_BITS, '0, '0, 7'd64, '0);
      send_beat(CMD_SETPOS, 10'd623, '0, '0, '0);
      send_beat(CMD_FRAC, '0, '0, '0, '0);
      send_beat(CMD_SETPOS, 10'd0, '0, '0, '0);
      send_beat(CMD_FRAC, '0, '0, '0, '0);
      // draw below: zero limit, smallest and largest limits, powers of two
      send_beat(CMD_BELOW, '0, '0, '0, 64'd0);
      send_beat(CMD_BELOW, '0, '0, '0, 64'd1);
      send_beat(CMD_BELOW, '0, '0, '0, 64'd3);
      send_beat(CMD_BELOW, '0, '0, '0, 64'h8000_0000_0000_0000);
      send_beat(CMD_BELOW, '0, '0, '0, 64'h8000_0000_0000_0001);
      send_beat(CMD_BELOW, '0, '0, '0, '1);
      for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
         send_beat(3'(c), '0, '0, '0, '0);
      end

      // Random mix. Dropped commands do not count toward the total. A middle
      // stretch and the tail run with no idling on either side.
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         calm = (sent >= 300 && sent < 380) || sent >= RANDOM_BEATS - 140;
         sel = $urandom_range(0, 99);
         if (sel < 10) begin
            idx = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(624, 1023))
                                              : 10'($urandom_range(0, 623));
            send_beat(CMD_LOAD, idx, $urandom, '0, '0);
         end else if (sel < 20) begin
            case ($urandom_range(0, 4))
               0:       idx = 10'($urandom_range(625, 1023));
               1:       idx = 10'($urandom_range(618, 624));
               default: idx = 10'($urandom_range(0, 624));
            endcase
            send_beat(CMD_SETPOS, idx, '0, '0, '0);
         end else if (sel < 50) begin
            nbits = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(1, 64));
            send_beat(CMD_BITS, '0, '0, nbits, '0);
         end else if (sel < 65) begin
            send_beat(CMD_FRAC, '0, '0, '0, '0);
         end else if (sel < 95) begin
            k = $urandom_range(0, 63);
            case ($urandom_range(0, 5))
               0: lim = rand64();
               1: lim = 64'($urandom_range(1, 1000));
               2: lim = 64'd1 << k;
               3: lim = (64'd1 << k) + 64'd1;
               4: lim = (64'd1 << k) - 64'd1;
               default: lim = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64() >> k;
            endcase
            send_beat(CMD_BELOW, '0, '0, '0, lim);
         end else begin
            send_beat(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), '0, '0, '0, '0);
            sent--;
         end
         sent++;
      end

      // Drain: drop tvalid, wait for every predicted result, then let the block settle.
      @(negedge clock);
      req_tvalid <= 1'b0;
      guard = 0;
      while (pending != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (64) @(posedge clock);
      @(negedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);

      $display("stimulus: %0d draws, %0d word loads, %0d position sets, %0d dropped commands",
               n_draws, n_loads, n_setpos, n_dropped);
      $display("compared %0d result beats, %0d of them flagged as errors",
               compared, error_results);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
